// File: rtl/linked_cell_neighbor_enumerator_unit_assert.svh
// assertion macros for the linked-cell neighbor enumerator
`ifndef LINKED_CELL_NEIGHBOR_ENUMERATOR_UNIT_ASSERT_SVH
`define LINKED_CELL_NEIGHBOR_ENUMERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define LCNE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lcne assertion failed");
`define LCNE_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lcne forbidden condition seen");
`else
`define LCNE_ASSERT(label, clk, rst, prop)
`define LCNE_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: rtl/lcne_pkg.sv
// shared widths, register map and offset codes of the neighbor enumerator
`timescale 1ns / 1ps

package lcne_pkg;

   // payload widths
   localparam int COORD_W = 6;
   localparam int GRID_W  = 7;
   localparam int INDEX_W = 18;

   // configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam int DEFAULT_MAX_DIM = 64;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_GRID_X = 2'd0;
   localparam logic [1:0] REG_GRID_Y = 2'd1;
   localparam logic [1:0] REG_GRID_Z = 2'd2;

   // neighbor offset codes, in the order they are walked
   localparam logic [1:0] OFF_ZERO  = 2'd0;
   localparam logic [1:0] OFF_PLUS  = 2'd1;
   localparam logic [1:0] OFF_MINUS = 2'd2;

endpackage

// File: rtl/lcne_intf.sv
// request and response channel interfaces of the neighbor enumerator
`timescale 1ns / 1ps

interface lcne_req_if;
   logic                         valid;
   logic                         ready;
   logic [lcne_pkg::COORD_W-1:0] cell_x;
   logic [lcne_pkg::COORD_W-1:0] cell_y;
   logic [lcne_pkg::COORD_W-1:0] cell_z;

   modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
   modport sink (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

interface lcne_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcne_pkg::INDEX_W-1:0] neighbor_index;
   logic                         last;
   logic                         bad_cell;

   modport source (output valid, output neighbor_index, output last, output bad_cell,
                   input ready);
   modport sink (input valid, input neighbor_index, input last, input bad_cell,
                 output ready);
endinterface

// File: rtl/linked_cell_neighbor_enumerator_unit.sv
// linked-cell 27-neighbor stencil enumerator: sequencer and index pipeline
// the first result of a request reaches rsp through stage 1, stage 2 and the stage 3 response register
// throughput: one neighbor index per cycle while rsp is ready; a request gives 27, 18 or 9 indexes
//   (fewer planes at the z boundaries or with one plane) and a single index for a bad cell
// the next request is taken in the cycle the current one issues its last index
// reset (synchronous, high) sets all three grid sizes to 1 and empties the pipe
`timescale 1ns / 1ps
`include "linked_cell_neighbor_enumerator_unit_assert.svh"

module linked_cell_neighbor_enumerator_unit #(
   parameter int MAX_DIM = lcne_pkg::DEFAULT_MAX_DIM
) (
   input  logic                        clock,
   input  logic                        reset,
   lcne_req_if.sink                    req_chan,
   lcne_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lcne_pkg::ADDR_W-1:0] paddr,
   input  logic [lcne_pkg::DATA_W-1:0] pwdata,
   output logic [lcne_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   localparam int GW     = lcne_pkg::GRID_W;
   localparam int TERM_W = 2 * GW + 1;
   localparam int PROD_W = GW + TERM_W + 1;
   // saturation limit as seen through a register of GRID_W bits
   localparam int SAT_DIM = (MAX_DIM > (2 ** GW) - 1) ? (2 ** GW) - 1 : MAX_DIM;

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   logic [GW-1:0] grid_x_ff, grid_y_ff, grid_z_ff;
   logic          csr_write;

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GW'(1);
         grid_y_ff <= GW'(1);
         grid_z_ff <= GW'(1);
      end else if (csr_write) begin
         case (paddr[3:2])
            lcne_pkg::REG_GRID_X: grid_x_ff <= pwdata[GW-1:0];
            lcne_pkg::REG_GRID_Y: grid_y_ff <= pwdata[GW-1:0];
            lcne_pkg::REG_GRID_Z: grid_z_ff <= pwdata[GW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         lcne_pkg::REG_GRID_X: prdata = {{(lcne_pkg::DATA_W - GW){1'b0}}, grid_x_ff};
         lcne_pkg::REG_GRID_Y: prdata = {{(lcne_pkg::DATA_W - GW){1'b0}}, grid_y_ff};
         lcne_pkg::REG_GRID_Z: prdata = {{(lcne_pkg::DATA_W - GW){1'b0}}, grid_z_ff};
         default:              prdata = '0;
      endcase
   end

   // effective sizes, clamped to the largest supported grid
   function automatic logic [GW-1:0] sat_dim(input logic [GW-1:0] r);
      return (r > GW'(SAT_DIM)) ? GW'(SAT_DIM) : r;
   endfunction

   // one periodic step: zero, plus one or minus one, wrapped into 0..n-1
   function automatic logic [GW-1:0] wrap_off(input logic [GW-1:0] c,
                                              input logic [GW-1:0] n,
                                              input logic [1:0]    code);
      logic [GW-1:0] res;
      res = c;
      case (code)
         lcne_pkg::OFF_PLUS:  res = (c + GW'(1) >= n) ? '0 : c + GW'(1);
         lcne_pkg::OFF_MINUS: res = (c == '0) ? n - GW'(1) : c - GW'(1);
         default:             res = c;
      endcase
      return res;
   endfunction

   logic [GW-1:0] gx_eff, gy_eff, gz_eff;
   assign gx_eff = sat_dim(grid_x_ff);
   assign gy_eff = sat_dim(grid_y_ff);
   assign gz_eff = sat_dim(grid_z_ff);

   // ---------------------------------------------------------------------------
   // pipeline advance: every stage moves when the output slot frees up
   // ---------------------------------------------------------------------------
   logic s3_valid_ff;
   logic advance;
   assign advance = !s3_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------------------
   // sequencer: walks plane, dx, dy for the request it holds
   // ---------------------------------------------------------------------------
   logic          busy_ff;
   logic [GW-1:0] x_ff, y_ff, z_ff;
   logic          bad_ff, has_lo_ff;
   logic [1:0]    last_pl_ff;
   logic [1:0]    pl_ff, dx_ff, dy_ff;

   logic          issue, seq_last, accept;
   logic [GW-1:0] req_x, req_y, req_z;
   logic          req_bad, req_lo, req_hi;
   logic [GW-1:0] plane_z;

   assign req_x   = GW'(req_chan.cell_x);
   assign req_y   = GW'(req_chan.cell_y);
   assign req_z   = GW'(req_chan.cell_z);
   assign req_bad = (req_x >= gx_eff) || (req_y >= gy_eff) || (req_z >= gz_eff);
   assign req_lo  = (req_z != '0);
   assign req_hi  = (req_z + GW'(1) < gz_eff);

   assign issue    = busy_ff && advance;
   assign seq_last = bad_ff || ((pl_ff == last_pl_ff) && (dx_ff == lcne_pkg::OFF_MINUS)
                                && (dy_ff == lcne_pkg::OFF_MINUS));
   // take the next request while the current one hands out its last index
   assign req_chan.ready = !busy_ff || (issue && seq_last);
   assign accept         = req_chan.valid && req_chan.ready;

   // plane order: own plane, then below (if any), then above (if any)
   always_comb begin
      case (pl_ff)
         2'd0:    plane_z = z_ff;
         2'd1:    plane_z = has_lo_ff ? z_ff - GW'(1) : z_ff + GW'(1);
         default: plane_z = z_ff + GW'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (issue && seq_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_x;
         y_ff       <= req_y;
         z_ff       <= req_z;
         bad_ff     <= req_bad;
         has_lo_ff  <= req_lo;
         last_pl_ff <= 2'({1'b0, req_lo}) + 2'({1'b0, req_hi});
         pl_ff      <= 2'd0;
         dx_ff      <= lcne_pkg::OFF_ZERO;
         dy_ff      <= lcne_pkg::OFF_ZERO;
      end else if (issue && !seq_last) begin
         if (dy_ff == lcne_pkg::OFF_MINUS) begin
            dy_ff <= lcne_pkg::OFF_ZERO;
            if (dx_ff == lcne_pkg::OFF_MINUS) begin
               dx_ff <= lcne_pkg::OFF_ZERO;
               pl_ff <= pl_ff + 2'd1;
            end else begin
               dx_ff <= dx_ff + 2'd1;
            end
         end else begin
            dy_ff <= dy_ff + 2'd1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stage 1: wrapped neighbor coordinates
   // ---------------------------------------------------------------------------
   logic          s1_valid_ff, s1_last_ff, s1_bad_ff;
   logic [GW-1:0] s1_x_ff, s1_y_ff, s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff    <= wrap_off(x_ff, gx_eff, dx_ff);
         s1_y_ff    <= wrap_off(y_ff, gy_eff, dy_ff);
         s1_z_ff    <= plane_z;
         s1_last_ff <= seq_last;
         s1_bad_ff  <= bad_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 2: row term y + ny*z
   // ---------------------------------------------------------------------------
   logic              s2_valid_ff, s2_last_ff, s2_bad_ff;
   logic [GW-1:0]     s2_x_ff;
   logic [TERM_W-1:0] s2_term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_x_ff    <= s1_x_ff;
         s2_term_ff <= TERM_W'(gy_eff) * TERM_W'(s1_z_ff) + TERM_W'(s1_y_ff);
         s2_last_ff <= s1_last_ff;
         s2_bad_ff  <= s1_bad_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 3: linear index x + nx*term, held as the response register
   // ---------------------------------------------------------------------------
   logic [PROD_W-1:0]            s3_full;
   logic [lcne_pkg::INDEX_W-1:0] s3_index_ff;
   logic                         s3_last_ff, s3_bad_ff;

   assign s3_full = PROD_W'(gx_eff) * PROD_W'(s2_term_ff) + PROD_W'(s2_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // a bad cell reports index zero
         s3_index_ff <= s2_bad_ff ? '0 : s3_full[lcne_pkg::INDEX_W-1:0];
         s3_last_ff  <= s2_last_ff;
         s3_bad_ff   <= s2_bad_ff;
      end
   end

   assign rsp_chan.valid          = s3_valid_ff;
   assign rsp_chan.neighbor_index = s3_index_ff;
   assign rsp_chan.last           = s3_last_ff;
   assign rsp_chan.bad_cell       = s3_bad_ff;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   `LCNE_ASSERT(a_bad_is_single, clock, reset,
                (s3_valid_ff && s3_bad_ff) |-> (s3_last_ff && (s3_index_ff == '0)))
   `LCNE_ASSERT(a_accept_when_free, clock, reset,
                accept |-> (!busy_ff || (issue && seq_last)))
   `LCNE_ASSERT(a_hold_on_stall, clock, reset,
                (busy_ff && !advance && !accept) |=>
                   ($stable(pl_ff) && $stable(dx_ff) && $stable(dy_ff)))
   `LCNE_ASSERT_NEVER(a_plane_range, clock, reset,
                      busy_ff && (pl_ff > last_pl_ff))

endmodule
